### src/sppe_pkg.sv
// sppe_pkg: shared types and constants for the SMS-PP envelope TLV parser.
// No dependencies; imported by sppe_parse and sms_pp_envelope_tlv_parser.
`default_nettype none

package sppe_pkg;

  localparam logic [7:0] TAG_ENVELOPE = 8'hD1;
  localparam logic [7:0] TAG_LONG_LEN = 8'h81;
  localparam logic [7:0] TAG_DEVICE   = 8'h82;
  localparam logic [7:0] TAG_ADDRESS  = 8'h86;
  localparam logic [7:0] TAG_TPDU     = 8'h8B;

  localparam logic [7:0] DEV_ID_LEN_RESET = 8'd2;

  typedef enum logic [1:0] {
    ST_BYTE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ENV_ERR  = 2'd2,
    ST_TPDU_ERR = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_ENV_LEN   = 4'd1,
    PH_ENV_LEN2  = 4'd2,
    PH_DEV_TAG   = 4'd3,
    PH_DEV_LEN   = 4'd4,
    PH_DEV_SKIP  = 4'd5,
    PH_ADDR_TAG  = 4'd6,
    PH_ADDR_LEN  = 4'd7,
    PH_ADDR_SKIP = 4'd8,
    PH_TPDU_TAG  = 4'd9,
    PH_TPDU_LEN  = 4'd10,
    PH_TPDU_LEN2 = 4'd11,
    PH_TPDU_DATA = 4'd12
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_command;
    logic [7:0] command_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tpdu_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

### src/sppe_parse.sv
// sppe_parse: parse phase state machine, one envelope byte per fire.
// Depends on sppe_pkg for tags, phase and status codes, and item types.
`default_nettype none

module sppe_parse (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  fire,
  input  sppe_pkg::in_item_t   item,
  input  wire  [7:0]           dev_id_len,
  output logic                 res_valid,
  output sppe_pkg::out_item_t  res_item,
  output sppe_pkg::phase_t     phase
);
  import sppe_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] saved_r, saved_nxt;
  logic [7:0] skip_r, skip_nxt;
  logic [7:0] rem_r, rem_nxt;

  logic [7:0] b;
  logic [7:0] pos_inc;
  logic [7:0] left;
  logic       len_ok;

  assign b       = item.byte_value;
  assign pos_inc = pos_r + 8'd1;
  // bytes remaining after this byte, mod 256
  assign left    = saved_r - (pos_inc + 8'd1);
  assign len_ok  = (left == b);
  assign phase   = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= 8'd0;
      saved_r <= 8'd0;
      skip_r  <= 8'd0;
      rem_r   <= 8'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      saved_r <= saved_nxt;
      skip_r  <= skip_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    saved_nxt = saved_r;
    skip_nxt  = skip_r;
    rem_nxt   = rem_r;
    if (item.start_of_command) begin
      saved_nxt = item.command_length;
      pos_nxt   = 8'd0;
      phase_nxt = (b == TAG_ENVELOPE) ? PH_ENV_LEN : PH_IDLE;
    end else begin
      if (phase_r != PH_IDLE) pos_nxt = pos_inc;
      case (phase_r)
        PH_ENV_LEN: begin
          if (b == TAG_LONG_LEN) phase_nxt = PH_ENV_LEN2;
          else                   phase_nxt = len_ok ? PH_DEV_TAG : PH_IDLE;
        end
        PH_ENV_LEN2: begin
          phase_nxt = len_ok ? PH_DEV_TAG : PH_IDLE;
        end
        PH_DEV_TAG: begin
          if      (b == TAG_DEVICE)  phase_nxt = PH_DEV_LEN;
          else if (b == TAG_ADDRESS) phase_nxt = PH_ADDR_LEN;
          else if (b == TAG_TPDU)    phase_nxt = PH_TPDU_LEN;
          else                       phase_nxt = PH_IDLE;
        end
        PH_DEV_LEN: begin
          // length byte itself is not read; size comes from the register
          skip_nxt  = dev_id_len;
          phase_nxt = (dev_id_len == 8'd0) ? PH_ADDR_TAG : PH_DEV_SKIP;
        end
        PH_DEV_SKIP: begin
          skip_nxt = skip_r - 8'd1;
          if (skip_r == 8'd1) phase_nxt = PH_ADDR_TAG;
        end
        PH_ADDR_TAG: begin
          if      (b == TAG_ADDRESS) phase_nxt = PH_ADDR_LEN;
          else if (b == TAG_TPDU)    phase_nxt = PH_TPDU_LEN;
          else                       phase_nxt = PH_IDLE;
        end
        PH_ADDR_LEN: begin
          skip_nxt  = b;
          phase_nxt = (b == 8'd0) ? PH_TPDU_TAG : PH_ADDR_SKIP;
        end
        PH_ADDR_SKIP: begin
          skip_nxt = skip_r - 8'd1;
          if (skip_r == 8'd1) phase_nxt = PH_TPDU_TAG;
        end
        PH_TPDU_TAG: begin
          phase_nxt = (b == TAG_TPDU) ? PH_TPDU_LEN : PH_IDLE;
        end
        PH_TPDU_LEN, PH_TPDU_LEN2: begin
          if (phase_r == PH_TPDU_LEN && b == TAG_LONG_LEN) begin
            phase_nxt = PH_TPDU_LEN2;
          end else if (!len_ok || b == 8'd0) begin
            phase_nxt = PH_IDLE;
          end else begin
            rem_nxt   = b;
            phase_nxt = PH_TPDU_DATA;
          end
        end
        PH_TPDU_DATA: begin
          rem_nxt = rem_r - 8'd1;
          if (rem_r == 8'd1) phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // result
  always_comb begin
    res_valid          = 1'b0;
    res_item.tpdu_byte = 8'd0;
    res_item.status    = ST_BYTE;
    res_item.last      = 1'b1;
    if (!item.start_of_command) begin
      case (phase_r)
        PH_ENV_LEN, PH_ENV_LEN2: begin
          if (!(phase_r == PH_ENV_LEN && b == TAG_LONG_LEN) && !len_ok) begin
            res_valid       = 1'b1;
            res_item.status = ST_ENV_ERR;
          end
        end
        PH_TPDU_LEN, PH_TPDU_LEN2: begin
          if (!(phase_r == PH_TPDU_LEN && b == TAG_LONG_LEN)) begin
            if (!len_ok) begin
              res_valid       = 1'b1;
              res_item.status = ST_TPDU_ERR;
            end else if (b == 8'd0) begin
              res_valid       = 1'b1;
              res_item.status = ST_EMPTY;
            end
          end
        end
        PH_TPDU_DATA: begin
          res_valid          = 1'b1;
          res_item.tpdu_byte = b;
          res_item.last      = (rem_r == 8'd1);
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/sms_pp_envelope_tlv_parser.sv
// Path: an accepted byte is held in the input register; its result, if any, is loaded
//   into the output register, which drives out_* until it is taken with out_stall low.
// Throughput: one byte per cycle; the input register refills while a result
//   waits in the output register, so only a stalled full output blocks input.
// Reset (rst_n, synchronous, active low): parser idle, counters zero,
//   device identity length back to 2, both pipeline registers empty.
`default_nettype none

module sms_pp_envelope_tlv_parser (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  sppe_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sppe_pkg::out_item_t  out_item,
  input  wire                  cfg_wr_en,
  input  wire  [7:0]           cfg_wr_data
);
  import sppe_pkg::*;

  // configuration: value length of the skipped 82 TLV
  logic [7:0] dev_id_len_r;

  // input register
  logic     in_valid_r;
  in_item_t in_item_r;

  // output register
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      in_fire;
  logic      advance;   // input register item is parsed this cycle
  logic      res_valid;
  out_item_t res_item;
  phase_t    phase;

  // the parse stage moves whenever the output register is free or draining
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_id_len_r <= DEV_ID_LEN_RESET;
    end else if (cfg_wr_en) begin
      dev_id_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_fire || (in_valid_r && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) in_item_r <= in_item;
  end

  sppe_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .item       (in_item_r),
    .dev_id_len (dev_id_len_r),
    .res_valid  (res_valid),
    .res_item   (res_item),
    .phase      (phase)
  );

  // output register: load a new result, or drop one that was taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) out_item_r <= res_item;
  end

  // errors and empty results always close the command
  a_non_byte_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.status != ST_BYTE) |-> out_item_r.last)
    else $error("non-data result without last");

  // a closing result returns the parser to idle
  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_valid && res_item.last |=> (phase == PH_IDLE))
    else $error("parser not idle after last result");

  // a held input item is never lost
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_item_r))
    else $error("input register lost a stalled item");

  // output register is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !advance)
    else $error("parse advanced into a stalled full output");

endmodule

`default_nettype wire
